>>> hdl/ycc2rgb_pkg.sv
// ----------------------------------------------------------------------------
// ycc2rgb_pkg
// Shared types and constants for the YCbCr to RGB converter with white balance.
// ----------------------------------------------------------------------------
package ycc2rgb_pkg;

  typedef struct packed {
    logic signed [15:0] luma;
    logic signed [15:0] chroma_blue;
    logic signed [15:0] chroma_red;
    logic               end_of_frame;
  } in_pix_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        frame_done;
  } out_pix_t;

  typedef enum logic [2:0] {
    CFG_MATRIX_MODE = 3'd0,
    CFG_HUE_OFFSET  = 3'd1,
    CFG_BLACK_LEVEL = 3'd2,
    CFG_GAIN_RED    = 3'd3,
    CFG_GAIN_GREEN  = 3'd4,
    CFG_GAIN_BLUE   = 3'd5
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int COEF_W     = 17;
  localparam int FRAC_SHIFT = 14;
  localparam int GAIN_SHIFT = 10;

  localparam logic [15:0] GAIN_UNITY = 16'd1024;
  localparam logic [15:0] CLAMP_MAX  = 16'd65535;

  // 17-bit signed matrix coefficients with a 14-bit fraction
  localparam logic signed [COEF_W-1:0] MAT_R1 = 17'sd50;
  localparam logic signed [COEF_W-1:0] MAT_R2 = 17'sd22929;
  localparam logic signed [COEF_W-1:0] MAT_G1 = -17'sd5640;
  localparam logic signed [COEF_W-1:0] MAT_G2 = -17'sd11751;
  localparam logic signed [COEF_W-1:0] MAT_B1 = 17'sd29040;
  localparam logic signed [COEF_W-1:0] MAT_B2 = -17'sd101;

  // offset mode scaled to the same 14-bit fraction
  localparam logic signed [COEF_W-1:0] OFS_ONE = 17'sd16384;
  localparam logic signed [COEF_W-1:0] OFS_G1  = -17'sd3112;
  localparam logic signed [COEF_W-1:0] OFS_G2  = -17'sd8192;
  localparam logic signed [COEF_W-1:0] COEF_ZERO = 17'sd0;

endpackage

>>> hdl/ycbcr_to_rgb_white_balance.sv
// ----------------------------------------------------------------------------
// ycbcr_to_rgb_white_balance
// Converts signed YCbCr pixels to white-balanced, clamped 16-bit RGB.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_data and raise start for one cycle per pixel. busy is
//   always low, so a request is taken at every edge where start is high and
//   a new pixel may follow in every cycle.
//   Output: out_valid is high for exactly one cycle with out_data; the
//   receiver must take it then and cannot stall the block.
//   Configuration: cfg_we, cfg_index and cfg_wdata write one register per
//   edge (0 mode, 1 hue, 2 black level, 3..5 red/green/blue gain); unknown
//   indexes are ignored. Write only while no pixel is in flight.
//   Pipeline: one register per stage, in this order: operand prepare,
//   coefficient multiply, sum and offset, gain multiply, shift and clamp.
//   Throughput: one pixel per cycle.
//   Reset: rst_n low at an edge empties the pipeline and loads register
//   defaults (offset mode, zero hue and black level, unity gains).
// ----------------------------------------------------------------------------
module ycbcr_to_rgb_white_balance
  import ycc2rgb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_pix_t               in_data,
  output logic                  out_valid,
  output out_pix_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic        matrix_mode_r;
  logic [7:0]  hue_offset_r;
  logic [9:0]  black_level_r;
  logic [15:0] gain_red_r;
  logic [15:0] gain_green_r;
  logic [15:0] gain_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_mode_r <= 1'b0;
      hue_offset_r  <= 8'd0;
      black_level_r <= 10'd0;
      gain_red_r    <= GAIN_UNITY;
      gain_green_r  <= GAIN_UNITY;
      gain_blue_r   <= GAIN_UNITY;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MATRIX_MODE: matrix_mode_r <= cfg_wdata[0];
        CFG_HUE_OFFSET:  hue_offset_r  <= cfg_wdata[7:0];
        CFG_BLACK_LEVEL: black_level_r <= cfg_wdata[9:0];
        CFG_GAIN_RED:    gain_red_r    <= cfg_wdata;
        CFG_GAIN_GREEN:  gain_green_r  <= cfg_wdata;
        CFG_GAIN_BLUE:   gain_blue_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid pipeline
  logic [4:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], start};
    end
  end

  // stage 1: operand prepare
  logic signed [15:0] s1_y_r, s1_a1_r, s1_a2_r;
  logic               s1_eof_r;
  logic signed [15:0] s1_a1_nxt, s1_a2_nxt;

  always_comb begin
    if (matrix_mode_r) begin
      s1_a1_nxt = {in_data.chroma_blue[13:0], 2'b00} + {8'd0, hue_offset_r};
      s1_a2_nxt = {in_data.chroma_red[13:0], 2'b00} + {8'd0, hue_offset_r};
    end else begin
      s1_a1_nxt = in_data.chroma_blue;
      s1_a2_nxt = in_data.chroma_red;
    end
  end

  always_ff @(posedge clk) begin
    s1_y_r   <= in_data.luma;
    s1_a1_r  <= s1_a1_nxt;
    s1_a2_r  <= s1_a2_nxt;
    s1_eof_r <= in_data.end_of_frame;
  end

  // stage 2: coefficient multiply
  logic signed [COEF_W-1:0] kr1, kr2, kg1, kg2, kb1, kb2;
  logic signed [32:0] s2_pr1_r, s2_pr2_r, s2_pg1_r, s2_pg2_r, s2_pb1_r, s2_pb2_r;
  logic signed [15:0] s2_y_r;
  logic               s2_eof_r;

  always_comb begin
    if (matrix_mode_r) begin
      kr1 = MAT_R1; kr2 = MAT_R2;
      kg1 = MAT_G1; kg2 = MAT_G2;
      kb1 = MAT_B1; kb2 = MAT_B2;
    end else begin
      kr1 = COEF_ZERO; kr2 = OFS_ONE;
      kg1 = OFS_G1;    kg2 = OFS_G2;
      kb1 = OFS_ONE;   kb2 = COEF_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    s2_pr1_r <= 33'(s1_a1_r) * 33'(kr1);
    s2_pr2_r <= 33'(s1_a2_r) * 33'(kr2);
    s2_pg1_r <= 33'(s1_a1_r) * 33'(kg1);
    s2_pg2_r <= 33'(s1_a2_r) * 33'(kg2);
    s2_pb1_r <= 33'(s1_a1_r) * 33'(kb1);
    s2_pb2_r <= 33'(s1_a2_r) * 33'(kb2);
    s2_y_r   <= s1_y_r;
    s2_eof_r <= s1_eof_r;
  end

  // stage 3: sum, fraction drop, luma add, black level subtract (offset mode only)
  logic signed [33:0] sum_r, sum_g, sum_b;
  logic signed [19:0] base_y, blk_eff;
  logic signed [19:0] frac_r, frac_g, frac_b;
  logic signed [17:0] s3_r_nxt, s3_g_nxt, s3_b_nxt;
  logic signed [17:0] s3_r_r, s3_g_r, s3_b_r;
  logic               s3_eof_r;

  always_comb begin
    sum_r    = 34'(s2_pr1_r) + 34'(s2_pr2_r);
    sum_g    = 34'(s2_pg1_r) + 34'(s2_pg2_r);
    sum_b    = 34'(s2_pb1_r) + 34'(s2_pb2_r);
    frac_r   = 20'(sum_r >>> FRAC_SHIFT);
    frac_g   = 20'(sum_g >>> FRAC_SHIFT);
    frac_b   = 20'(sum_b >>> FRAC_SHIFT);
    base_y   = 20'(s2_y_r);
    blk_eff  = matrix_mode_r ? 20'sd0 : $signed({10'd0, black_level_r});
    s3_r_nxt = 18'(base_y + frac_r - blk_eff);
    s3_g_nxt = 18'(base_y + frac_g - blk_eff);
    s3_b_nxt = 18'(base_y + frac_b - blk_eff);
  end

  always_ff @(posedge clk) begin
    s3_r_r   <= s3_r_nxt;
    s3_g_r   <= s3_g_nxt;
    s3_b_r   <= s3_b_nxt;
    s3_eof_r <= s2_eof_r;
  end

  // stage 4: gain multiply
  logic signed [34:0] s4_r_r, s4_g_r, s4_b_r;
  logic               s4_eof_r;

  always_ff @(posedge clk) begin
    s4_r_r   <= 35'(s3_r_r) * 35'($signed({1'b0, gain_red_r}));
    s4_g_r   <= 35'(s3_g_r) * 35'($signed({1'b0, gain_green_r}));
    s4_b_r   <= 35'(s3_b_r) * 35'($signed({1'b0, gain_blue_r}));
    s4_eof_r <= s3_eof_r;
  end

  // stage 5: shift and clamp
  function automatic logic [15:0] clamp16(input logic signed [34:0] prod);
    logic signed [24:0] v;
    begin
      v = 25'(prod >>> GAIN_SHIFT);
      if (v < 0) begin
        clamp16 = 16'd0;
      end else if (v > $signed({9'd0, CLAMP_MAX})) begin
        clamp16 = CLAMP_MAX;
      end else begin
        clamp16 = v[15:0];
      end
    end
  endfunction

  out_pix_t out_data_nxt, out_data_r;

  always_comb begin
    out_data_nxt.red        = clamp16(s4_r_r);
    out_data_nxt.green      = clamp16(s4_g_r);
    out_data_nxt.blue       = clamp16(s4_b_r);
    out_data_nxt.frame_done = s4_eof_r;
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = vld_r[4];
  assign out_data  = out_data_r;

endmodule
